/* src/cbsm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbsm_pkg: shared types and constants of the bank-switch mapper
// Field widths, access codes, board variants, register map and reset values.
// ----------------------------------------------------------------------------
package cbsm_pkg;

    localparam int MODE_W     = 2;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int MAP_ADDR_W = 19;

    localparam int CHR_SLOTS  = 8;
    localparam int SLOT_W     = $clog2(CHR_SLOTS);
    localparam int CHR_BANK_W = 9;
    localparam int PRG_BANK_W = 5;
    localparam int PRG_CNT_W  = 6;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOARD_VARIANT  = 2'd0,
        CFG_PRG_BANK_COUNT = 2'd1,
        CFG_FOUR_SCREEN    = 2'd2
    } cfg_index_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_CPU_WRITE = 2'd0,
        MODE_CPU_READ  = 2'd1,
        MODE_PPU_READ  = 2'd2
    } access_mode_t;

    typedef enum logic [1:0] {
        VARIANT_21 = 2'd0,
        VARIANT_22 = 2'd1,
        VARIANT_23 = 2'd2,
        VARIANT_25 = 2'd3
    } board_variant_t;

    typedef enum logic [1:0] {
        MIRR_VERTICAL   = 2'd0,
        MIRR_HORIZONTAL = 2'd1,
        MIRR_SINGLE_0   = 2'd2,
        MIRR_SINGLE_1   = 2'd3
    } mirroring_t;

    // register groups by the top nibble of the rewired address
    localparam logic [3:0] HI_PRG_A     = 4'h8;
    localparam logic [3:0] HI_CTRL      = 4'h9;
    localparam logic [3:0] HI_PRG_B     = 4'hA;
    localparam logic [3:0] HI_CHR_FIRST = 4'hB;
    localparam logic [3:0] HI_CHR_LAST  = 4'hE;

    localparam logic [DATA_W-1:0] MIRR_ALL_ONES = 8'hFF;
    localparam logic [5:0]        PALETTE_PAGE  = 6'h3F;

    localparam logic [1:0]            RST_VARIANT    = VARIANT_21;
    localparam logic [PRG_CNT_W-1:0]  RST_PRG_COUNT  = 6'd32;
    localparam logic [PRG_CNT_W-1:0]  MIN_PRG_COUNT  = 6'd2;
    localparam logic [PRG_BANK_W-1:0] RST_PRG_BANK_A = 5'd0;
    localparam logic [PRG_BANK_W-1:0] RST_PRG_BANK_B = 5'd1;

endpackage
`default_nettype wire

/* src/cbsm_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbsm_if: request and response channels of the bank-switch mapper
// Valid/ready channels; an item moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface cbsm_req_if
    import cbsm_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;

    modport source (output valid, output mode, output address, output data, input ready);
    modport sink   (input valid, input mode, input address, input data, output ready);
endinterface

interface cbsm_rsp_if
    import cbsm_pkg::*;
    ();
    logic                  valid;
    logic                  ready;
    logic                  mapped_valid;
    logic                  is_nametable;
    logic [MAP_ADDR_W-1:0] mapped_address;
    logic                  nametable_page;

    modport source (output valid, output mapped_valid, output is_nametable,
                    output mapped_address, output nametable_page, input ready);
    modport sink   (input valid, input mapped_valid, input is_nametable,
                    input mapped_address, input nametable_page, output ready);
endinterface
`default_nettype wire

/* src/cartridge_bank_switch_mapper_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cartridge_bank_switch_mapper_unit: bank-switching mapper, boards 21/22/23/25
// Decodes CPU register writes and maps CPU and PPU reads to ROM offsets.
// ----------------------------------------------------------------------------
// Usage:
//   req  - one bus access per item: mode (CPU write, CPU read, PPU read),
//          address and write data.
//   rsp  - exactly one item per request item, in order: mapped_valid,
//          is_nametable, mapped_address, nametable_page. Writes answer zeros.
//   cfg  - cfg_we/cfg_index/cfg_wdata set board variant, PRG bank count and
//          four-screen; write only while no item is in flight.
// Timing:
//   An item is held in an input register, decoded in one pass against the
//   bank state and lands in the result register, which drives rsp.valid.
//   One item per cycle is sustained while rsp.ready stays high; the figure
//   is set by the single decode stage that reads and updates the bank
//   registers. A write takes effect for every item accepted after it.
// Stalls: while rsp is held the input register still takes one more item;
//   req.ready then drops until the result register drains.
// Reset: rst_n clears both stages, config to its defaults (variant 21, 32
//   PRG banks, four-screen off) and banks to A=0, B=1, swap off, vertical
//   mirroring, all CHR banks zero.
// ----------------------------------------------------------------------------
module cartridge_bank_switch_mapper_unit
    import cbsm_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    cbsm_req_if.sink             req,
    cbsm_rsp_if.source           rsp,
    input  wire                  cfg_we,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0] cfg_wdata
);

    // configuration
    logic [1:0]           variant_reg;
    logic [PRG_CNT_W-1:0] prg_count_reg;
    logic                 four_screen_reg;

    // bank state
    logic [PRG_BANK_W-1:0] prg_bank_a_reg, prg_bank_a_next;
    logic [PRG_BANK_W-1:0] prg_bank_b_reg, prg_bank_b_next;
    logic                  prg_swap_reg, prg_swap_next;
    logic [1:0]            mirroring_reg, mirroring_next;
    logic [CHR_BANK_W-1:0] chr_bank_reg [CHR_SLOTS];
    logic [CHR_BANK_W-1:0] chr_bank_next [CHR_SLOTS];

    // input stage
    logic              s1_valid_reg;
    logic [MODE_W-1:0] s1_mode_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [DATA_W-1:0] s1_data_reg;

    // result stage
    logic                  out_valid_reg;
    logic                  out_mvalid_reg, out_mvalid_next;
    logic                  out_nt_reg, out_nt_next;
    logic [MAP_ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic                  out_page_reg, out_page_next;

    logic s1_fire;
    logic req_fire;

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_fire;
    assign req_fire = req.valid && req.ready;

    // ---------------------------------------------------------------------
    // register-write decode: address lines rewired per board variant
    // (rewired address always carries only two low bits, so all land in
    // the register file range)
    // ---------------------------------------------------------------------
    logic [3:0]      wr_hi;
    logic [1:0]      wr_lo;
    logic [3:0]      chr_ofs;
    logic [SLOT_W-1:0] wr_slot;
    logic [1:0]      mirr_wr;
    logic            wr_en;

    assign wr_hi = s1_addr_reg[15:12];

    always_comb
    begin
        case (board_variant_t'(variant_reg))
            VARIANT_21: wr_lo = s1_addr_reg[2:1] | s1_addr_reg[7:6];
            VARIANT_22: wr_lo = {s1_addr_reg[0], s1_addr_reg[1]};
            VARIANT_23: wr_lo = s1_addr_reg[1:0] | s1_addr_reg[3:2];
            VARIANT_25: wr_lo = {s1_addr_reg[0] | s1_addr_reg[2],
                                 s1_addr_reg[1] | s1_addr_reg[3]};
            default:    wr_lo = s1_addr_reg[1:0];
        endcase
    end

    assign chr_ofs = wr_hi - HI_CHR_FIRST;
    assign wr_slot = {chr_ofs[1:0], wr_lo[1]};

    // board 22 keeps one mirroring bit; board 23 reads all ones as horizontal
    always_comb
    begin
        case (board_variant_t'(variant_reg))
            VARIANT_22: mirr_wr = {1'b0, s1_data_reg[0]};
            VARIANT_23: mirr_wr = (s1_data_reg == MIRR_ALL_ONES) ? MIRR_HORIZONTAL
                                                                 : s1_data_reg[1:0];
            default:    mirr_wr = s1_data_reg[1:0];
        endcase
    end

    assign wr_en = s1_fire && (access_mode_t'(s1_mode_reg) == MODE_CPU_WRITE)
                   && s1_addr_reg[15];

    always_comb
    begin
        prg_bank_a_next = prg_bank_a_reg;
        prg_bank_b_next = prg_bank_b_reg;
        prg_swap_next   = prg_swap_reg;
        mirroring_next  = mirroring_reg;
        for (int i = 0; i < CHR_SLOTS; i++)
        begin
            chr_bank_next[i] = chr_bank_reg[i];
        end
        if (wr_en)
        begin
            case (wr_hi) inside
                HI_PRG_A: prg_bank_a_next = s1_data_reg[PRG_BANK_W-1:0];
                HI_CTRL:
                begin
                    if (wr_lo[1])
                    begin
                        prg_swap_next = s1_data_reg[1];
                    end
                    else if (!four_screen_reg)
                    begin
                        mirroring_next = mirr_wr;
                    end
                end
                HI_PRG_B: prg_bank_b_next = s1_data_reg[PRG_BANK_W-1:0];
                [HI_CHR_FIRST:HI_CHR_LAST]:
                begin
                    if (wr_lo[0])
                    begin
                        chr_bank_next[wr_slot] = {s1_data_reg[4:0], chr_bank_reg[wr_slot][3:0]};
                    end
                    else
                    begin
                        chr_bank_next[wr_slot] = {chr_bank_reg[wr_slot][8:4], s1_data_reg[3:0]};
                    end
                end
                default: ; // IRQ block and unused groups
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // read mapping
    // ---------------------------------------------------------------------
    logic [PRG_CNT_W-1:0]  prg_count_eff;
    logic [PRG_CNT_W-1:0]  prg_last;
    logic [PRG_CNT_W-1:0]  prg_last_m1;
    logic [PRG_CNT_W-1:0]  prg_bank;
    logic [13:0]           ppu_addr;
    logic [CHR_BANK_W-1:0] chr_bank;

    assign prg_count_eff = (prg_count_reg < MIN_PRG_COUNT) ? MIN_PRG_COUNT : prg_count_reg;
    assign prg_last      = prg_count_eff - PRG_CNT_W'(1);
    assign prg_last_m1   = prg_count_eff - PRG_CNT_W'(2);

    // 8 KB windows at 0x8000/0xA000/0xC000/0xE000; swap exchanges first and third
    always_comb
    begin
        case (s1_addr_reg[14:13])
            2'd0:    prg_bank = prg_swap_reg ? prg_last_m1 : {1'b0, prg_bank_a_reg};
            2'd1:    prg_bank = {1'b0, prg_bank_b_reg};
            2'd2:    prg_bank = prg_swap_reg ? {1'b0, prg_bank_a_reg} : prg_last_m1;
            default: prg_bank = prg_last;
        endcase
    end

    assign ppu_addr = s1_addr_reg[13:0];
    assign chr_bank = (board_variant_t'(variant_reg) == VARIANT_22)
                      ? (chr_bank_reg[ppu_addr[12:10]] >> 1)
                      : chr_bank_reg[ppu_addr[12:10]];

    always_comb
    begin
        out_mvalid_next = 1'b0;
        out_nt_next     = 1'b0;
        out_addr_next   = '0;
        out_page_next   = 1'b0;
        case (access_mode_t'(s1_mode_reg))
            MODE_CPU_READ:
            begin
                if (s1_addr_reg[15])
                begin
                    out_mvalid_next = 1'b1;
                    out_addr_next   = {prg_bank, s1_addr_reg[12:0]};
                end
            end
            MODE_PPU_READ:
            begin
                if (!ppu_addr[13])
                begin
                    out_mvalid_next = 1'b1;
                    out_addr_next   = {chr_bank, ppu_addr[9:0]};
                end
                else if (ppu_addr[13:8] != PALETTE_PAGE)
                begin
                    out_mvalid_next = 1'b1;
                    out_nt_next     = 1'b1;
                    case (mirroring_t'(mirroring_reg))
                        MIRR_VERTICAL:   out_page_next = ppu_addr[10];
                        MIRR_HORIZONTAL: out_page_next = ppu_addr[11];
                        MIRR_SINGLE_0:   out_page_next = 1'b0;
                        default:         out_page_next = 1'b1;
                    endcase
                end
            end
            default: ; // writes and unused code answer zeros
        endcase
    end

    // ---------------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg     <= RST_VARIANT;
            prg_count_reg   <= RST_PRG_COUNT;
            four_screen_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_BOARD_VARIANT:  variant_reg     <= cfg_wdata[1:0];
                CFG_PRG_BANK_COUNT: prg_count_reg   <= cfg_wdata;
                CFG_FOUR_SCREEN:    four_screen_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_bank_a_reg <= RST_PRG_BANK_A;
            prg_bank_b_reg <= RST_PRG_BANK_B;
            prg_swap_reg   <= 1'b0;
            mirroring_reg  <= MIRR_VERTICAL;
            for (int i = 0; i < CHR_SLOTS; i++)
            begin
                chr_bank_reg[i] <= '0;
            end
        end
        else
        begin
            prg_bank_a_reg <= prg_bank_a_next;
            prg_bank_b_reg <= prg_bank_b_next;
            prg_swap_reg   <= prg_swap_next;
            mirroring_reg  <= mirroring_next;
            for (int i = 0; i < CHR_SLOTS; i++)
            begin
                chr_bank_reg[i] <= chr_bank_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_mode_reg <= req.mode;
            s1_addr_reg <= req.address;
            s1_data_reg <= req.data;
        end
        if (s1_fire)
        begin
            out_mvalid_reg <= out_mvalid_next;
            out_nt_reg     <= out_nt_next;
            out_addr_reg   <= out_addr_next;
            out_page_reg   <= out_page_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.mapped_valid   = out_mvalid_reg;
    assign rsp.is_nametable   = out_nt_reg;
    assign rsp.mapped_address = out_addr_reg;
    assign rsp.nametable_page = out_page_reg;

endmodule
`default_nettype wire

/* src/cbsm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbsm_checker: port-level checks of the bank-switch mapper
// Watches the response channel; bound into the mapper unit below.
// ----------------------------------------------------------------------------
module cbsm_checker
    import cbsm_pkg::*;
(
    input wire                  clk,
    input wire                  rst_n,
    input wire                  rsp_valid,
    input wire                  rsp_ready,
    input wire                  rsp_mapped_valid,
    input wire                  rsp_is_nametable,
    input wire [MAP_ADDR_W-1:0] rsp_mapped_address,
    input wire                  rsp_nametable_page
);

    // nothing leaves while in reset; checked in the next cycle, once the reset
    // has been seen by the registers whatever order time zero ran in
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !rsp_valid)
        else $error("rsp.valid high during reset");

    // a held item stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mapped_valid)
            && $stable(rsp_is_nametable) && $stable(rsp_mapped_address)
            && $stable(rsp_nametable_page))
        else $error("stalled rsp item changed");

    // unmapped items carry all zeros
    a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_mapped_valid |->
            !rsp_is_nametable && rsp_mapped_address == '0 && !rsp_nametable_page)
        else $error("unmapped item has non-zero fields");

    // nametable hits carry no ROM offset; ROM hits no page
    a_nt_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_mapped_valid |->
            (rsp_is_nametable && rsp_mapped_address == '0)
            || (!rsp_is_nametable && !rsp_nametable_page))
        else $error("mapped item mixes nametable and ROM fields");

endmodule

bind cartridge_bank_switch_mapper_unit cbsm_checker u_cbsm_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_mapped_valid   (rsp.mapped_valid),
    .rsp_is_nametable   (rsp.is_nametable),
    .rsp_mapped_address (rsp.mapped_address),
    .rsp_nametable_page (rsp.nametable_page)
);
`default_nettype wire

/* verif/cartridge_bank_switch_mapper_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_switch_mapper_unit_tb: self-checking bench for the mapper
// Drives CPU writes, CPU reads and PPU reads through the request channel
// under every board variant, and checks each result item against a model
// of the bank registers.
// ----------------------------------------------------------------------------
module cartridge_bank_switch_mapper_unit_tb;
    import cbsm_pkg::*;

    // mode code with no access behind it; the block must answer all zeros
    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;
    localparam int                PHASES        = 8;
    localparam int                ITEMS_PER_PHASE = 165;

    typedef struct packed {
        logic                  mapped_valid;
        logic                  is_nametable;
        logic [MAP_ADDR_W-1:0] mapped_address;
        logic                  nametable_page;
    } map_result_t;

    // receiver stall styles
    typedef enum int {
        SINK_STREAM,
        SINK_COIN,
        SINK_QUARTER,
        SINK_LONG
    } sink_style_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the bank registers and configuration,
    // works out the result of every accepted access and queues it in order.
    // ------------------------------------------------------------------------
    class mapper_scoreboard;
        board_variant_t        variant;
        logic [PRG_CNT_W-1:0]  bank_count;
        logic                  quad_screen;
        logic [PRG_BANK_W-1:0] prg_a;
        logic [PRG_BANK_W-1:0] prg_b;
        logic                  swap;
        mirroring_t            mirr;
        logic [CHR_BANK_W-1:0] chr [CHR_SLOTS];
        map_result_t           expected_maps [$];
        int                    mismatches;

        function new();
            variant     = VARIANT_21;
            bank_count  = RST_PRG_COUNT;
            quad_screen = 1'b0;
            prg_a       = RST_PRG_BANK_A;
            prg_b       = RST_PRG_BANK_B;
            swap        = 1'b0;
            mirr        = MIRR_VERTICAL;
            for (int i = 0; i < CHR_SLOTS; i++)
                chr[i] = '0;
            mismatches  = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_BOARD_VARIANT:  variant = board_variant_t'(v[1:0]);
                CFG_PRG_BANK_COUNT: bank_count = v;
                CFG_FOUR_SCREEN:    quad_screen = v[0];
                default: ;
            endcase
        endfunction

        function void note_access(logic [MODE_W-1:0] m, logic [ADDR_W-1:0] a,
                                  logic [DATA_W-1:0] d);
            map_result_t           r;
            logic [1:0]            sel;
            logic [3:0]            grp;
            logic [3:0]            grp_off;
            logic [SLOT_W-1:0]     slot;
            logic [PRG_CNT_W-1:0]  cnt;
            logic [PRG_CNT_W-1:0]  bank;
            logic [CHR_BANK_W-1:0] cbank;
            logic [13:0]           p;
            r = '0;
            case (m)
                MODE_CPU_WRITE:
                    if (a[15])
                    begin
                        grp = a[15:12];
                        // board wiring of the two low register-select lines
                        case (variant)
                            VARIANT_21: sel = a[2:1] | a[7:6];
                            VARIANT_22: sel = {a[0], a[1]};
                            VARIANT_23: sel = a[1:0] | a[3:2];
                            default:    sel = {a[0] | a[2], a[1] | a[3]};
                        endcase
                        case (grp)
                            HI_PRG_A: prg_a = d[PRG_BANK_W-1:0];
                            HI_PRG_B: prg_b = d[PRG_BANK_W-1:0];
                            HI_CTRL:
                                if (sel[1])
                                    swap = d[1];
                                else if (!quad_screen)
                                begin
                                    if (variant == VARIANT_22)
                                        mirr = mirroring_t'({1'b0, d[0]});
                                    else if (variant == VARIANT_23 && d == MIRR_ALL_ONES)
                                        mirr = MIRR_HORIZONTAL;
                                    else
                                        mirr = mirroring_t'(d[1:0]);
                                end
                            default:
                                if (grp >= HI_CHR_FIRST && grp <= HI_CHR_LAST)
                                begin
                                    grp_off = grp - HI_CHR_FIRST;
                                    slot    = {grp_off[1:0], sel[1]};
                                    if (sel[0])
                                        chr[slot][8:4] = d[4:0];
                                    else
                                        chr[slot][3:0] = d[3:0];
                                end
                        endcase
                    end
                MODE_CPU_READ:
                    if (a[15])
                    begin
                        cnt = (bank_count < MIN_PRG_COUNT) ? MIN_PRG_COUNT : bank_count;
                        case (a[14:13])
                            2'd0:    bank = swap ? cnt - 6'd2 : {1'b0, prg_a};
                            2'd1:    bank = {1'b0, prg_b};
                            2'd2:    bank = swap ? {1'b0, prg_a} : cnt - 6'd2;
                            default: bank = cnt - 6'd1;
                        endcase
                        r.mapped_valid   = 1'b1;
                        r.mapped_address = {bank, a[12:0]};
                    end
                MODE_PPU_READ:
                begin
                    p = a[13:0];
                    if (!p[13])
                    begin
                        cbank = chr[p[12:10]];
                        if (variant == VARIANT_22)
                            cbank = cbank >> 1;
                        r.mapped_valid   = 1'b1;
                        r.mapped_address = {cbank, p[9:0]};
                    end
                    else if (p[13:8] != PALETTE_PAGE)
                    begin
                        r.mapped_valid = 1'b1;
                        r.is_nametable = 1'b1;
                        case (mirr)
                            MIRR_VERTICAL:   r.nametable_page = p[10];
                            MIRR_HORIZONTAL: r.nametable_page = p[11];
                            MIRR_SINGLE_0:   r.nametable_page = 1'b0;
                            default:         r.nametable_page = 1'b1;
                        endcase
                    end
                end
                default: ;
            endcase
            expected_maps.push_back(r);
        endfunction

        function void check_result(map_result_t got);
            map_result_t want;
            if (expected_maps.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: result item with nothing outstanding: %p", $realtime, got);
                mismatches++;
            end
            else
            begin
                want = expected_maps.pop_front();
                if (got.mapped_valid !== want.mapped_valid ||
                    got.is_nametable !== want.is_nametable ||
                    got.mapped_address !== want.mapped_address ||
                    got.nametable_page !== want.nametable_page)
                begin
                    if (mismatches < 10)
                        $display("%0t: mismatch exp v=%0b nt=%0b addr=%05h page=%0b, got v=%0b nt=%0b addr=%05h page=%0b",
                                 $realtime, want.mapped_valid, want.is_nametable,
                                 want.mapped_address, want.nametable_page,
                                 got.mapped_valid, got.is_nametable,
                                 got.mapped_address, got.nametable_page);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    cbsm_req_if req_ch ();
    cbsm_rsp_if rsp_ch ();

    cartridge_bank_switch_mapper_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    mapper_scoreboard sb;

    // sender burst state
    int burst_left;

    // receiver stall state
    sink_style_t sink_style;
    int          style_left;
    int          hold_left;
    int          quarter_cnt;
    logic        hold_level;

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Receiver: ready changes on the falling edge. The style is picked anew
    // after a run of random length so that stalls land on every phase of the
    // block's two-stage pipe, with full-rate stretches in between.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (style_left == 0)
            begin
                sink_style = sink_style_t'($urandom_range(0, 3));
                style_left = $urandom_range(20, 120);
            end
            style_left--;
            case (sink_style)
                SINK_STREAM:  rsp_ch.ready <= 1'b1;
                SINK_COIN:    rsp_ch.ready <= 1'($urandom_range(0, 1));
                SINK_QUARTER:
                begin
                    quarter_cnt++;
                    rsp_ch.ready <= (quarter_cnt % 4 == 0);
                end
                default:
                begin
                    // long stall / short release pairs
                    if (hold_left == 0)
                    begin
                        hold_level = ~hold_level;
                        hold_left  = hold_level ? $urandom_range(1, 8) : $urandom_range(1, 16);
                    end
                    hold_left--;
                    rsp_ch.ready <= hold_level;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: both handshakes are sampled on the rising edge. No result can
    // come back in the cycle its access is taken, so order here is free.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        map_result_t got;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                sb.note_access(req_ch.mode, req_ch.address, req_ch.data);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.mapped_valid   = rsp_ch.mapped_valid;
                got.is_nametable   = rsp_ch.is_nametable;
                got.mapped_address = rsp_ch.mapped_address;
                got.nametable_page = rsp_ch.nametable_page;
                sb.check_result(got);
            end
        end
    end

    // One access on the request channel. Called and returns on a falling
    // edge. Between bursts valid drops for a random number of cycles, or not at all.
    task automatic send_access(logic [MODE_W-1:0] m, logic [ADDR_W-1:0] a,
                               logic [DATA_W-1:0] d);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        req_ch.valid   <= 1'b1;
        req_ch.mode    <= m;
        req_ch.address <= a;
        req_ch.data    <= d;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // Holds the sender until every outstanding result is back, then lets the
    // pipe settle; the block must be idle before its registers are touched.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (sb.expected_maps.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Writes all three configuration registers, one per cycle.
    task automatic set_board(logic [1:0] v, logic [PRG_CNT_W-1:0] cnt, logic quad);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BOARD_VARIANT;
        cfg_wdata <= {4'd0, v};
        sb.set_reg(CFG_BOARD_VARIANT, {4'd0, v});
        @(negedge clk);
        cfg_index <= CFG_PRG_BANK_COUNT;
        cfg_wdata <= cnt;
        sb.set_reg(CFG_PRG_BANK_COUNT, cnt);
        @(negedge clk);
        cfg_index <= CFG_FOUR_SCREEN;
        cfg_wdata <= {5'd0, quad};
        sb.set_reg(CFG_FOUR_SCREEN, {5'd0, quad});
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Random access. Most CPU writes land in the register window (every
    // address there but the IRQ group decodes to some register), with a share
    // of 0xFF data to hit the variant 23 mirroring quirk. Reads mostly hit ROM space.
    task automatic random_access();
        int                sel;
        logic [ADDR_W-1:0] a;
        logic [DATA_W-1:0] d;
        sel = $urandom_range(0, 99);
        a   = ADDR_W'($urandom);
        d   = DATA_W'($urandom);
        if (sel < 30)
        begin
            if ($urandom_range(0, 9) != 0)
                a[15] = 1'b1;
            if ($urandom_range(0, 7) == 0)
                d = MIRR_ALL_ONES;
            send_access(MODE_CPU_WRITE, a, d);
        end
        else if (sel < 65)
        begin
            a[15] = ($urandom_range(0, 7) != 0);
            send_access(MODE_CPU_READ, a, d);
        end
        else if (sel < 99)
            send_access(MODE_PPU_READ, a, d);
        else
            send_access(MODE_RESERVED, a, d);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [1:0]           ph_variant;
        logic [PRG_CNT_W-1:0] ph_count;
        logic                 ph_quad;

        sb             = new();
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_BOARD_VARIANT;
        cfg_wdata      = '0;
        req_ch.valid   = 1'b0;
        req_ch.mode    = MODE_CPU_WRITE;
        req_ch.address = '0;
        req_ch.data    = '0;
        rsp_ch.ready   = 1'b0;
        burst_left     = 0;
        style_left     = 0;
        hold_left      = 0;
        quarter_cnt    = 0;
        hold_level     = 1'b0;
        sink_style     = SINK_STREAM;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part under the reset configuration (variant 21, 32 banks)
        send_access(MODE_CPU_READ, 16'h7FFF, 8'h00);   // PRG RAM space: zeros
        send_access(MODE_CPU_READ, 16'h8000, 8'h00);
        send_access(MODE_CPU_READ, 16'hA000, 8'h00);
        send_access(MODE_CPU_READ, 16'hC000, 8'h00);
        send_access(MODE_CPU_READ, 16'hFFFF, 8'hFF);
        send_access(MODE_PPU_READ, 16'h0000, 8'h00);
        send_access(MODE_PPU_READ, 16'h1FFF, 8'h00);
        send_access(MODE_PPU_READ, 16'h2000, 8'h00);
        send_access(MODE_PPU_READ, 16'h2400, 8'h00);
        send_access(MODE_PPU_READ, 16'h3EFF, 8'h00);
        send_access(MODE_PPU_READ, 16'h3F00, 8'h00);   // palette
        send_access(MODE_PPU_READ, 16'hFFFF, 8'h00);   // top bits dropped: palette
        send_access(MODE_CPU_WRITE, 16'h8000, 8'hFF);  // PRG A = 31
        send_access(MODE_CPU_WRITE, 16'hA000, 8'h00);  // PRG B = 0
        send_access(MODE_CPU_WRITE, 16'h9004, 8'h02);  // swap on
        send_access(MODE_CPU_READ, 16'h8000, 8'h00);
        send_access(MODE_CPU_READ, 16'hC000, 8'h00);
        send_access(MODE_CPU_READ, 16'hA000, 8'h00);
        send_access(MODE_CPU_WRITE, 16'h9000, 8'h03);  // single page 1
        send_access(MODE_PPU_READ, 16'h2000, 8'h00);
        send_access(MODE_CPU_WRITE, 16'hB000, 8'h0F);  // CHR 0 low nibble
        send_access(MODE_CPU_WRITE, 16'hB002, 8'h1F);  // CHR 0 high bits
        send_access(MODE_PPU_READ, 16'h03FF, 8'h00);   // top of the first CHR window
        send_access(MODE_CPU_WRITE, 16'hF000, 8'hFF);  // IRQ register: ignored
        send_access(MODE_RESERVED, 16'hFFFF, 8'hFF);
        send_access(MODE_CPU_WRITE, 16'h7FFF, 8'hFF);  // below the window

        // phases: every variant, bank counts at and past both ends,
        // four-screen on and off
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            ph_variant = 2'(ph % 4);
            case (ph)
                0:       ph_count = 6'd32;
                1:       ph_count = MIN_PRG_COUNT;
                2:       ph_count = 6'd1;                  // clamps to two
                3:       ph_count = 6'd32;
                4:       ph_count = 6'($urandom_range(2, 32));
                5:       ph_count = MIN_PRG_COUNT;
                6:       ph_count = 6'd0;                  // clamps to two
                default: ph_count = 6'($urandom_range(2, 63));
            endcase
            ph_quad = (ph == 3 || ph == 4 || ph == 7);
            set_board(ph_variant, ph_count, ph_quad);

            // mirroring write of all ones, then probe both nametable lines
            send_access(MODE_CPU_WRITE, 16'h9000, MIRR_ALL_ONES);
            send_access(MODE_PPU_READ, 16'h2400, 8'h00);
            send_access(MODE_PPU_READ, 16'h2800, 8'h00);
            send_access(MODE_PPU_READ, 16'h0400, 8'h00);
            send_access(MODE_CPU_READ, 16'hC000, 8'h00);
            send_access(MODE_CPU_READ, 16'hE000, 8'h00);

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                random_access();
        end

        wait_drained();

        if (sb.mismatches == 0 && sb.expected_maps.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
